@@ src/hhs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhs_pkg
// Shared constants, status codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package hhs_pkg;

    localparam int SLOTS     = 128;
    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int MAX_HOP   = 32;
    localparam int POS_W     = $clog2(MAX_HOP);
    localparam int KEY_W     = 32;
    localparam int HOP_W     = 6;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int MOVES_W   = 6;
    localparam int STATUS_W  = 3;
    localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(25);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } res_status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_RM_HIT,
        OP_SET_NF,
        OP_SET_DUP,
        OP_SET_FULL,
        OP_HOME_RD,
        OP_CH_START,
        OP_F_STEP,
        OP_CH_OK,
        OP_CH_FAIL,
        OP_CH_STEP,
        OP_S_RD,
        OP_S_STEP,
        OP_CH_PICK,
        OP_SAVE_L,
        OP_SAVE_R,
        OP_SET_FREE_F,
        OP_SET_FULL_MV,
        OP_PLACE,
        OP_HOP_RD,
        OP_HOP_WR,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   ch_ltr;
        logic   ch_apply;
    } dp_cmd_t;

    typedef struct packed {
        logic func_rm;
        logic key_hit;
        logic scan_last;
        logic have_free;
        logic home_full;
        logic init_more;
        logic init_used;
        logic in_win;
        logic steps_full;
        logic s_eq_f;
        logic skip;
        logic ltr;
        logic apply;
        logic ch_ok;
        logic lok;
        logic rok;
        logic pick_rtl;
        logic out_free;
    } dp_flags_t;

endpackage

@@ src/hopscotch_hash_set_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopscotch_hash_set_top
// Hopscotch hash set of 32-bit keys, 128 slots, insert and remove.
//
//   channel   ports                                 beat
//   s_        s_valid s_ready s_func s_key          one operation
//   m_        m_valid m_ready m_status m_slot m_moves  one result
//   cfg_      cfg_valid cfg_ready cfg_hop_range     window width write
//
// Remove or duplicate: window slots are read and checked, stopping at a hit.
// Insert into a free slot: full window scan, then placement and hop update.
// Displacement: two trial chains plus the applied one; each candidate slot
// is read then checked, and each applied move reads and writes a hop word.
// Valid bits clear the tables at reset; no clearing pass.
// A waiting result does not block the next operation's scan.
// ----------------------------------------------------------------------------
module hopscotch_hash_set_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic signed [hhs_pkg::KEY_W-1:0]   s_key,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hhs_pkg::STATUS_W-1:0]       m_status,
    output logic [hhs_pkg::ADDR_W-1:0]         m_slot,
    output logic [hhs_pkg::MOVES_W-1:0]        m_moves,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hhs_pkg::HOP_W-1:0]          cfg_hop_range
);

    hhs_pkg::dp_cmd_t   cmd;
    hhs_pkg::dp_flags_t flags;

    hhs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    hhs_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .flags         (flags),
        .s_func        (s_func),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_moves       (m_moves),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_hop_range (cfg_hop_range)
    );

endmodule

@@ src/hhs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhs_dp
// Table storage, window scan and displacement chain datapath.
// ----------------------------------------------------------------------------
module hhs_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hhs_pkg::dp_cmd_t                   cmd,
    output hhs_pkg::dp_flags_t                 flags,
    input  logic                               s_func,
    input  logic signed [hhs_pkg::KEY_W-1:0]   s_key,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hhs_pkg::STATUS_W-1:0]       m_status,
    output logic [hhs_pkg::ADDR_W-1:0]         m_slot,
    output logic [hhs_pkg::MOVES_W-1:0]        m_moves,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hhs_pkg::HOP_W-1:0]          cfg_hop_range
);

    localparam int AW = hhs_pkg::ADDR_W;
    localparam int KW = hhs_pkg::KEY_W;
    localparam int HW = hhs_pkg::HOP_W;
    localparam int CW = hhs_pkg::CNT_W;
    localparam int MH = hhs_pkg::MAX_HOP;
    localparam int PW = hhs_pkg::POS_W;

    logic [KW-1:0] mem_key  [hhs_pkg::SLOTS];
    logic [AW-1:0] mem_home [hhs_pkg::SLOTS];
    logic [MH-1:0] mem_hop  [hhs_pkg::SLOTS];
    logic [hhs_pkg::SLOTS-1:0] used_reg;
    logic [hhs_pkg::SLOTS-1:0] hop_vld_reg;

    logic [HW-1:0] hop_range_reg;
    logic [KW-1:0] key_reg;
    logic          func_reg;
    logic [PW-1:0] i_reg;
    logic [AW-1:0] c_reg;
    logic [AW-1:0] free_reg;
    logic          have_free_reg;
    logic [AW-1:0] f_reg;
    logic [AW-1:0] s_reg;
    logic [CW-1:0] steps_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] lc_reg;
    logic [CW-1:0] rc_reg;
    logic          lok_reg;
    logic          rok_reg;
    logic          ch_ok_reg;
    logic          ltr_reg;
    logic          apply_reg;
    logic [AW-1:0] hop_o_reg;
    logic          clr_en_reg;
    logic [AW-1:0] clr_pos_reg;
    logic          set_en_reg;
    logic [AW-1:0] set_pos_reg;
    logic [hhs_pkg::STATUS_W-1:0] res_status_reg;
    logic [AW-1:0] res_slot_reg;
    logic [hhs_pkg::MOVES_W-1:0] moves_reg;
    logic          m_valid_reg;
    logic [hhs_pkg::STATUS_W-1:0] m_status_reg;
    logic [AW-1:0] m_slot_reg;
    logic [hhs_pkg::MOVES_W-1:0] m_moves_reg;

    logic [KW-1:0] key_q;
    logic [AW-1:0] home_q;
    logic [MH-1:0] hop_q;
    logic          hop_v_q;

    logic [HW-1:0] hw;
    logic [AW-1:0] hw_a;
    logic [AW-1:0] home;
    logic [AW-1:0] border;
    logic [AW-1:0] stop;
    logic [MH-1:0] mask;
    logic [MH-1:0] hop_word;
    logic [MH-1:0] clr_mask;
    logic [MH-1:0] set_mask;
    logic [MH-1:0] new_hop;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   d_full;
    logic [AW-1:0] d_low;
    logic [AW-1:0] o;
    logic          skip_l;
    logic          skip_r;
    logic [hhs_pkg::MOVES_W-1:0] cnt_sat;
    logic          tbl_we;
    logic [AW-1:0] tbl_wa;
    logic [KW-1:0] tbl_wkey;
    logic [AW-1:0] tbl_whome;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (hop_range_reg == '0) begin
            hw = HW'(1);
        end else if (hop_range_reg > HW'(MH)) begin
            hw = HW'(MH);
        end else begin
            hw = hop_range_reg;
        end
    end

    assign hw_a     = AW'(hw);
    assign home     = key_reg[AW-1:0];
    assign border   = home + hw_a;
    assign stop     = ltr_reg ? home : border;
    assign mask     = (hw == HW'(MH)) ? '1 : ((MH'(1) << hw) - MH'(1));
    assign hop_word = hop_v_q ? hop_q : '0;
    assign clr_mask = (clr_en_reg && clr_pos_reg < AW'(MH)) ? (MH'(1) << clr_pos_reg[PW-1:0]) : '0;
    assign set_mask = (set_en_reg && set_pos_reg < AW'(MH)) ? (MH'(1) << set_pos_reg[PW-1:0]) : '0;
    assign new_hop  = (hop_word & ~clr_mask) | set_mask;
    assign cnt_sat  = (cnt_reg > CW'(63)) ? hhs_pkg::MOVES_W'(63) : cnt_reg[hhs_pkg::MOVES_W-1:0];

    // candidate bound checks, on the home read back for slot s
    assign o      = home_q;
    assign d_full = {1'b0, o} + (AW+1)'(hw) - (AW+1)'(1);
    assign d_low  = d_full[AW-1:0];
    assign skip_l = (s_reg < f_reg && d_low < f_reg) ||
                    (s_reg > f_reg && (d_low < f_reg || !d_full[AW]));
    assign skip_r = (f_reg < s_reg && o > f_reg && s_reg >= o) ||
                    (f_reg > s_reg && ((s_reg >= o && o < f_reg) || (s_reg < o && o > f_reg)));

    always_comb begin
        flags.func_rm    = func_reg;
        flags.key_hit    = used_reg[c_reg] && (key_q == key_reg);
        flags.scan_last  = (i_reg == PW'(hw - HW'(1)));
        flags.have_free  = have_free_reg;
        flags.home_full  = ((hop_word & mask) == mask);
        flags.init_more  = (f_reg != stop) && used_reg[f_reg];
        flags.init_used  = used_reg[f_reg];
        flags.in_win     = (AW'(f_reg - home) < hw_a);
        flags.steps_full = (steps_reg == CW'(hhs_pkg::SLOTS));
        flags.s_eq_f     = (s_reg == f_reg);
        flags.skip       = ltr_reg ? skip_l : skip_r;
        flags.ltr        = ltr_reg;
        flags.apply      = apply_reg;
        flags.ch_ok      = ch_ok_reg;
        flags.lok        = lok_reg;
        flags.rok        = rok_reg;
        flags.pick_rtl   = rok_reg && (!lok_reg || rc_reg <= lc_reg);
        flags.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        unique case (cmd.op)
            hhs_pkg::OP_SCAN_RD: rd_addr = home + AW'(i_reg);
            hhs_pkg::OP_HOME_RD: rd_addr = home;
            hhs_pkg::OP_S_RD:    rd_addr = s_reg;
            hhs_pkg::OP_HOP_RD:  rd_addr = hop_o_reg;
            default:             rd_addr = c_reg;
        endcase
    end

    always_comb begin
        tbl_we    = 1'b0;
        tbl_wa    = f_reg;
        tbl_wkey  = key_q;
        tbl_whome = home_q;
        if (cmd.op == hhs_pkg::OP_CH_PICK && apply_reg) begin
            tbl_we = 1'b1;
        end else if (cmd.op == hhs_pkg::OP_PLACE) begin
            tbl_we    = 1'b1;
            tbl_wa    = free_reg;
            tbl_wkey  = key_reg;
            tbl_whome = home;
        end
    end

    always_ff @(posedge aclk) begin
        key_q   <= mem_key[rd_addr];
        home_q  <= mem_home[rd_addr];
        hop_q   <= mem_hop[rd_addr];
        hop_v_q <= hop_vld_reg[rd_addr];
        if (tbl_we) begin
            mem_key[tbl_wa]  <= tbl_wkey;
            mem_home[tbl_wa] <= tbl_whome;
        end
        if (cmd.op == hhs_pkg::OP_HOP_WR) begin
            mem_hop[hop_o_reg] <= new_hop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            hop_vld_reg   <= '0;
            hop_range_reg <= hhs_pkg::HOP_RESET;
            steps_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                hop_range_reg <= cfg_hop_range;
            end
            if (cmd.op == hhs_pkg::OP_RM_HIT) begin
                used_reg[c_reg] <= 1'b0;
            end
            if (cmd.op == hhs_pkg::OP_CH_PICK && apply_reg) begin
                used_reg[f_reg] <= 1'b1;
                used_reg[s_reg] <= 1'b0;
            end
            if (cmd.op == hhs_pkg::OP_PLACE) begin
                used_reg[free_reg] <= 1'b1;
            end
            if (cmd.op == hhs_pkg::OP_HOP_WR) begin
                hop_vld_reg[hop_o_reg] <= 1'b1;
            end
            if (cmd.op == hhs_pkg::OP_CH_START) begin
                steps_reg <= '0;
            end else if (cmd.op == hhs_pkg::OP_CH_STEP) begin
                steps_reg <= steps_reg + CW'(1);
            end
            if (cmd.op == hhs_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            hhs_pkg::OP_START: begin
                key_reg        <= s_key;
                func_reg       <= s_func;
                i_reg          <= '0;
                have_free_reg  <= 1'b0;
                res_status_reg <= hhs_pkg::ST_INSERTED;
                res_slot_reg   <= '0;
                moves_reg      <= '0;
            end
            hhs_pkg::OP_SCAN_RD: c_reg <= rd_addr;
            hhs_pkg::OP_SCAN_NEXT: begin
                if (!used_reg[c_reg] && !have_free_reg) begin
                    free_reg      <= c_reg;
                    have_free_reg <= 1'b1;
                end
                i_reg <= i_reg + PW'(1);
            end
            hhs_pkg::OP_RM_HIT: begin
                res_status_reg <= hhs_pkg::ST_REMOVED;
                res_slot_reg   <= c_reg;
                hop_o_reg      <= home_q;
                clr_en_reg     <= 1'b1;
                clr_pos_reg    <= c_reg - home_q;
                set_en_reg     <= 1'b0;
            end
            hhs_pkg::OP_SET_NF:   res_status_reg <= hhs_pkg::ST_NOT_FOUND;
            hhs_pkg::OP_SET_DUP:  res_status_reg <= hhs_pkg::ST_DUPLICATE;
            hhs_pkg::OP_SET_FULL: res_status_reg <= hhs_pkg::ST_FULL;
            hhs_pkg::OP_CH_START: begin
                ltr_reg   <= cmd.ch_ltr;
                apply_reg <= cmd.ch_apply;
                f_reg     <= cmd.ch_ltr ? border : home - AW'(1);
                cnt_reg   <= '0;
            end
            hhs_pkg::OP_F_STEP:  f_reg <= ltr_reg ? f_reg + AW'(1) : f_reg - AW'(1);
            hhs_pkg::OP_CH_OK:   ch_ok_reg <= 1'b1;
            hhs_pkg::OP_CH_FAIL: ch_ok_reg <= 1'b0;
            hhs_pkg::OP_CH_STEP: begin
                s_reg <= ltr_reg ? f_reg - hw_a + AW'(1) : f_reg + hw_a - AW'(1);
            end
            hhs_pkg::OP_S_STEP:  s_reg <= ltr_reg ? s_reg + AW'(1) : s_reg - AW'(1);
            hhs_pkg::OP_CH_PICK: begin
                cnt_reg <= cnt_reg + CW'(1);
                f_reg   <= s_reg;
                if (apply_reg) begin
                    hop_o_reg   <= home_q;
                    clr_en_reg  <= 1'b1;
                    clr_pos_reg <= s_reg - home_q;
                    set_en_reg  <= 1'b1;
                    set_pos_reg <= f_reg - home_q;
                end
            end
            hhs_pkg::OP_SAVE_L: begin
                lok_reg <= ch_ok_reg;
                lc_reg  <= cnt_reg;
            end
            hhs_pkg::OP_SAVE_R: begin
                rok_reg <= ch_ok_reg;
                rc_reg  <= cnt_reg;
            end
            hhs_pkg::OP_SET_FREE_F: begin
                free_reg  <= f_reg;
                moves_reg <= cnt_sat;
            end
            hhs_pkg::OP_SET_FULL_MV: begin
                res_status_reg <= hhs_pkg::ST_FULL;
                moves_reg      <= cnt_sat;
            end
            hhs_pkg::OP_PLACE: begin
                res_slot_reg <= free_reg;
                hop_o_reg    <= home;
                clr_en_reg   <= 1'b0;
                set_en_reg   <= 1'b1;
                set_pos_reg  <= free_reg - home;
            end
            hhs_pkg::OP_OUT: begin
                m_status_reg <= res_status_reg;
                m_slot_reg   <= res_slot_reg;
                m_moves_reg  <= moves_reg;
            end
            default: ;
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_moves  = m_moves_reg;

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == hhs_pkg::OP_OUT |=> m_valid_reg)
        else $error("result not presented after load");
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= CW'(hhs_pkg::SLOTS))
        else $error("chain step count past table size");
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == hhs_pkg::ST_DUPLICATE ||
        m_status_reg == hhs_pkg::ST_NOT_FOUND || m_status_reg == hhs_pkg::ST_FULL)
        |-> m_slot_reg == '0)
        else $error("slot nonzero for failed operation");
    a_moves_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == hhs_pkg::ST_DUPLICATE ||
        m_status_reg == hhs_pkg::ST_NOT_FOUND || m_status_reg == hhs_pkg::ST_REMOVED)
        |-> m_moves_reg == '0)
        else $error("moves reported without displacement");

endmodule

@@ src/hhs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhs_ctrl
// Sequencer for scan, displacement chains, placement and hop word updates.
// ----------------------------------------------------------------------------
module hhs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hhs_pkg::dp_flags_t  flags,
    output hhs_pkg::dp_cmd_t    cmd
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_SCAN_RD  = 16'h0002,
        S_SCAN_CHK = 16'h0004,
        S_SCAN_END = 16'h0008,
        S_HOME_CHK = 16'h0010,
        S_CH_INIT  = 16'h0020,
        S_CH_LOOP  = 16'h0040,
        S_S_RD     = 16'h0080,
        S_S_CHK    = 16'h0100,
        S_CH_END   = 16'h0200,
        S_START_R  = 16'h0400,
        S_DECIDE   = 16'h0800,
        S_PLACE    = 16'h1000,
        S_HOP_RD   = 16'h2000,
        S_HOP_WR   = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cmd.op       = hhs_pkg::OP_NONE;
        cmd.ch_ltr   = 1'b1;
        cmd.ch_apply = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = hhs_pkg::OP_START;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.op     = hhs_pkg::OP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                priority if (flags.func_rm && flags.key_hit) begin
                    cmd.op     = hhs_pkg::OP_RM_HIT;
                    ret_next   = S_DONE;
                    state_next = S_HOP_RD;
                end else if (flags.func_rm && flags.scan_last) begin
                    cmd.op     = hhs_pkg::OP_SET_NF;
                    state_next = S_DONE;
                end else if (flags.func_rm) begin
                    cmd.op     = hhs_pkg::OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end else if (flags.key_hit) begin
                    cmd.op     = hhs_pkg::OP_SET_DUP;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = hhs_pkg::OP_SCAN_NEXT;
                    state_next = flags.scan_last ? S_SCAN_END : S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (flags.have_free) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = hhs_pkg::OP_HOME_RD;
                    state_next = S_HOME_CHK;
                end
            end
            S_HOME_CHK: begin
                if (flags.home_full) begin
                    cmd.op     = hhs_pkg::OP_SET_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = hhs_pkg::OP_CH_START;
                    state_next = S_CH_INIT;
                end
            end
            S_CH_INIT: begin
                priority if (flags.init_more) begin
                    cmd.op = hhs_pkg::OP_F_STEP;
                end else if (flags.init_used) begin
                    cmd.op     = hhs_pkg::OP_CH_FAIL;
                    state_next = S_CH_END;
                end else begin
                    state_next = S_CH_LOOP;
                end
            end
            S_CH_LOOP: begin
                priority if (flags.in_win) begin
                    cmd.op     = hhs_pkg::OP_CH_OK;
                    state_next = S_CH_END;
                end else if (flags.steps_full) begin
                    cmd.op     = hhs_pkg::OP_CH_FAIL;
                    state_next = S_CH_END;
                end else begin
                    cmd.op     = hhs_pkg::OP_CH_STEP;
                    state_next = S_S_RD;
                end
            end
            S_S_RD: begin
                if (flags.s_eq_f) begin
                    cmd.op     = hhs_pkg::OP_CH_FAIL;
                    state_next = S_CH_END;
                end else begin
                    cmd.op     = hhs_pkg::OP_S_RD;
                    state_next = S_S_CHK;
                end
            end
            S_S_CHK: begin
                if (flags.skip) begin
                    cmd.op     = hhs_pkg::OP_S_STEP;
                    state_next = S_S_RD;
                end else begin
                    cmd.op = hhs_pkg::OP_CH_PICK;
                    if (flags.apply) begin
                        ret_next   = S_CH_LOOP;
                        state_next = S_HOP_RD;
                    end else begin
                        state_next = S_CH_LOOP;
                    end
                end
            end
            S_CH_END: begin
                priority if (flags.apply && flags.ch_ok) begin
                    cmd.op     = hhs_pkg::OP_SET_FREE_F;
                    state_next = S_PLACE;
                end else if (flags.apply) begin
                    cmd.op     = hhs_pkg::OP_SET_FULL_MV;
                    state_next = S_DONE;
                end else if (flags.ltr) begin
                    cmd.op     = hhs_pkg::OP_SAVE_L;
                    state_next = S_START_R;
                end else begin
                    cmd.op     = hhs_pkg::OP_SAVE_R;
                    state_next = S_DECIDE;
                end
            end
            S_START_R: begin
                cmd.op     = hhs_pkg::OP_CH_START;
                cmd.ch_ltr = 1'b0;
                state_next = S_CH_INIT;
            end
            S_DECIDE: begin
                if (!flags.lok && !flags.rok) begin
                    cmd.op     = hhs_pkg::OP_SET_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd.op       = hhs_pkg::OP_CH_START;
                    cmd.ch_ltr   = !flags.pick_rtl;
                    cmd.ch_apply = 1'b1;
                    state_next   = S_CH_INIT;
                end
            end
            S_PLACE: begin
                cmd.op     = hhs_pkg::OP_PLACE;
                ret_next   = S_DONE;
                state_next = S_HOP_RD;
            end
            S_HOP_RD: begin
                cmd.op     = hhs_pkg::OP_HOP_RD;
                state_next = S_HOP_WR;
            end
            S_HOP_WR: begin
                cmd.op     = hhs_pkg::OP_HOP_WR;
                state_next = ret_reg;
            end
            S_DONE: begin
                if (flags.out_free) begin
                    cmd.op     = hhs_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_SCAN_RD)
        else $error("accepted beat did not start a scan");
    a_hop_return: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_HOP_WR |-> (ret_reg == S_DONE || ret_reg == S_CH_LOOP))
        else $error("bad return after hop word update");

endmodule
